>>> hw/rtl/blpg_pkg.sv
// Shared types, constants and lookup functions of the boot logo pixel generator.
package blpg_pkg;

    // Frame and port geometry.
    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

    // Iterative pipelines: stages and recurrence steps per stage.
    localparam int ITER_STAGES     = 8;
    localparam int STEPS_PER_STAGE = 3;
    localparam int ISQ_RAD_W       = 2 * ITER_STAGES * STEPS_PER_STAGE;
    localparam int ISQ_ROOT_W      = ITER_STAGES * STEPS_PER_STAGE;
    localparam int ISQ_REM_W       = ISQ_ROOT_W + 3;
    localparam int MOD_DIVD_W      = ITER_STAGES * STEPS_PER_STAGE;
    localparam int MOD_DIV_W       = 14;

    // Reciprocals for division by constants (multiply, then shift).
    localparam logic [27:0] RCP_DIV5     = 28'd214748365;   // 2^30 / 5
    localparam logic [26:0] RCP_DIV10000 = 27'd109951163;   // 2^40 / 10000
    localparam logic [23:0] RCP_DIV500   = 24'd8589935;     // 2^32 / 500
    localparam logic [24:0] RCP_DIV225   = 25'd19088744;    // 2^32 / 225
    localparam logic [24:0] RCP_DIV15    = 25'd17895698;    // 2^28 / 15

    // Per-pixel flags and values that ride alongside the long pipelines.
    typedef struct packed {
        logic        in_frame;
        logic        robot;
        logic        bar;
        logic [7:0]  glow;
        logic [16:0] pulse;
        logic [12:0] xy;
        logic [15:0] lo;
    } t_side;

    // Digit-by-digit square root state.
    typedef struct packed {
        logic [ISQ_RAD_W-1:0]  rad;
        logic [ISQ_REM_W-1:0]  rem;
        logic [ISQ_ROOT_W-1:0] root;
    } t_isq_st;

    // Bit-serial remainder state.
    typedef struct packed {
        logic [MOD_DIVD_W-1:0] divd;
        logic [MOD_DIV_W-1:0]  rem;
    } t_mod_st;

    // Quarter-wave sine table, Q1.15.
    function automatic logic [15:0] sine_q(input logic [4:0] idx);
        logic [15:0] v;
        unique case (idx)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd3212;
            5'd2:    v = 16'd6393;
            5'd3:    v = 16'd9512;
            5'd4:    v = 16'd12540;
            5'd5:    v = 16'd15447;
            5'd6:    v = 16'd18205;
            5'd7:    v = 16'd20788;
            5'd8:    v = 16'd23170;
            5'd9:    v = 16'd25330;
            5'd10:   v = 16'd27246;
            5'd11:   v = 16'd28899;
            5'd12:   v = 16'd30274;
            5'd13:   v = 16'd31357;
            5'd14:   v = 16'd32138;
            5'd15:   v = 16'd32610;
            5'd16:   v = 16'd32768;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // Fraction floor(r * 16384 / 5) for a remainder of division by five.
    function automatic logic [13:0] lo5_frac(input logic [2:0] r);
        logic [13:0] v;
        unique case (r)
            3'd1:    v = 14'd3276;
            3'd2:    v = 14'd6553;
            3'd3:    v = 14'd9830;
            3'd4:    v = 14'd13107;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

    // Several square root steps: bring in two radicand bits, try 4q+1.
    function automatic t_isq_st isq_stage(input t_isq_st st);
        t_isq_st              v;
        logic [ISQ_REM_W-1:0] cur;
        logic [ISQ_REM_W-1:0] trial;
        v = st;
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            cur   = {v.rem[ISQ_REM_W-3:0], v.rad[ISQ_RAD_W-1 -: 2]};
            trial = ISQ_REM_W'({v.root, 2'b01});
            v.rad = {v.rad[ISQ_RAD_W-3:0], 2'b00};
            if (cur >= trial) begin
                v.rem  = cur - trial;
                v.root = {v.root[ISQ_ROOT_W-2:0], 1'b1};
            end else begin
                v.rem  = cur;
                v.root = {v.root[ISQ_ROOT_W-2:0], 1'b0};
            end
        end
        return v;
    endfunction

    // Several restoring remainder steps, one dividend bit each.
    function automatic t_mod_st mod_stage(input t_mod_st st, input logic [MOD_DIV_W-1:0] div);
        t_mod_st            v;
        logic [MOD_DIV_W:0] cur;
        v = st;
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            cur    = {v.rem, v.divd[MOD_DIVD_W-1]};
            v.divd = {v.divd[MOD_DIVD_W-2:0], 1'b0};
            if (cur >= {1'b0, div}) begin
                cur = cur - {1'b0, div};
            end
            v.rem = cur[MOD_DIV_W-1:0];
        end
        return v;
    endfunction

endpackage

>>> hw/rtl/blpg_if.sv
// Request channels of the boot logo pixel generator: pixel in, color out, configuration.
interface blpg_pix_if import blpg_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [23:0] time_ms;

    modport source (output valid, pixel_x, pixel_y, time_ms, input ready);
    modport sink   (input valid, pixel_x, pixel_y, time_ms, output ready);
endinterface

interface blpg_out_if import blpg_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [31:0] pixel_rgba;
    logic        inside_res;

    modport source (output valid, pixel_rgba, inside_res, input ready);
    modport sink   (input valid, pixel_rgba, inside_res, output ready);
endinterface

interface blpg_cfg_if import blpg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/blpg_isqrt_pipe.sv
// Pipelined integer square root, a few digit steps per register stage.
module blpg_isqrt_pipe import blpg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ISQ_RAD_W-1:0]  i_rad,
    output logic [ISQ_ROOT_W-1:0] o_root
);

    t_isq_st r_st [ITER_STAGES];
    t_isq_st n_st [ITER_STAGES];

    // Each stage advances the recurrence on the state left by the one before.
    for (genvar s = 0; s < ITER_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            always_comb begin
                n_st[s] = isq_stage('{rad: i_rad, rem: '0, root: '0});
            end
        end else begin : g_next
            always_comb begin
                n_st[s] = isq_stage(r_st[s-1]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    assign o_root = r_st[ITER_STAGES-1].root;

endmodule

>>> hw/rtl/blpg_mod_pipe.sv
// Pipelined remainder of a dividend by the frame-dependent shimmer period.
module blpg_mod_pipe import blpg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [MOD_DIVD_W-1:0] i_divd,
    input  logic [MOD_DIV_W-1:0]  i_div,
    output logic [MOD_DIV_W-1:0]  o_rem
);

    t_mod_st r_st [ITER_STAGES];
    t_mod_st n_st [ITER_STAGES];

    // The user must change the divisor only while the block is idle; it is not enforced.
    for (genvar s = 0; s < ITER_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            always_comb begin
                n_st[s] = mod_stage('{divd: i_divd, rem: '0}, i_div);
            end
        end else begin : g_next
            always_comb begin
                n_st[s] = mod_stage(r_st[s-1], i_div);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    assign o_rem = r_st[ITER_STAGES-1].rem;

endmodule

>>> hw/rtl/boot_logo_pixel_generator_top.sv
// Top level of the boot logo pixel generator: geometry, shading and output pipeline.
//
//   channel  | dir | payload                          | accepted when
//   ---------+-----+----------------------------------+----------------------------
//   i_pix    | in  | pixel_x, pixel_y, time_ms        | i_pix.valid & i_pix.ready
//   o_pix    | out | pixel_rgba, inside_res           | o_pix.valid & o_pix.ready
//   i_cfg    | in  | index, data (frame width/height) | i_cfg.valid (ready is high)
//
// One pixel request is taken every clock while the output is not stalled.
// The pipeline includes the eight-stage square root and shimmer remainder pipelines.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads a 720 x 1280 frame.
// A stall at the output freezes every stage together, so no request is lost or repeated.
module boot_logo_pixel_generator_top import blpg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    blpg_pix_if.sink    i_pix,
    blpg_cfg_if.sink    i_cfg,
    blpg_out_if.source  o_pix
);

    localparam int NSTG = ITER_STAGES + 8;

    logic             en;
    logic [NSTG-1:0]  r_vld;
    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    logic [DIM_W-1:0] frm_w;
    logic [DIM_W-1:0] frm_h;
    logic [MOD_DIV_W-1:0] shim_period;

    // Stage A.
    logic               n_a_inside, r_a_inside;
    logic signed [13:0] n_a_dx, r_a_dx, n_a_dy, r_a_dy;
    logic [12:0]        n_a_xy, r_a_xy;
    logic [27:0]        n_a_t9, r_a_t9;
    logic [26:0]        n_a_t7, r_a_t7;
    logic [34:0]        a_t2003;
    logic [5:0]         r_a_p;

    // Stage B.
    logic signed [14:0] b_dx, b_dy, b_hy, b_ey, b_lx, b_rx;
    logic signed [29:0] b_pdx, b_pdy, b_phy, b_pey, b_plx, b_prx;
    logic [55:0]        b_prod5;
    logic [53:0]        b_prod10k;
    logic [1:0]         b_quad;
    logic [4:0]         b_sidx;
    logic [29:0]        b_amp;
    logic [16:0]        n_b_pulse;
    logic [25:0]        r_b_sx, r_b_sy, r_b_shy, r_b_sey, r_b_slx, r_b_srx;
    logic signed [13:0] r_b_dx, r_b_dy;
    logic [25:0]        r_b_q5;
    logic [13:0]        r_b_q10k;
    logic [27:0]        r_b_t9;
    logic [26:0]        r_b_t7;
    logic [16:0]        r_b_pulse;
    logic               r_b_inside;
    logic [12:0]        r_b_xy;

    // Stage C.
    logic [25:0]        c_d2;
    logic signed [17:0] c_a1, c_a2;
    logic               c_head, c_ant, c_torso, c_arm, c_leg, c_bar;
    logic [27:0]        c_q5x5, c_r5full;
    logic [26:0]        c_q10x, c_r10full;
    t_side              n_c_side, r_c_side;
    logic [ISQ_RAD_W-1:0]  r_c_rad;
    logic [MOD_DIVD_W-1:0] r_c_hi;
    logic [13:0]        r_c_r10k;
    logic signed [13:0] r_c_dx;

    // Stages D and E: progress bar glow.
    logic [16:0]        d_n13;
    logic [40:0]        d_prod;
    t_side              r_d_side;
    logic [8:0]         r_d_off;
    logic signed [13:0] r_d_dx;
    logic signed [14:0] e_diff;
    logic [14:0]        e_abs;
    logic [8:0]         e_g17;
    t_side              n_e_side, r_e_side;
    t_side              r_dl [ITER_STAGES-2];

    // Iterative pipeline results.
    logic [ISQ_ROOT_W-1:0] isq_root;
    logic [MOD_DIV_W-1:0]  mod_rem;

    // Stages F to J.
    logic [48:0]        f_prod;
    t_side              r_f_side;
    logic               r_f_far;
    logic [15:0]        r_f_q225;
    logic signed [31:0] r_f_sweep;
    logic signed [31:0] g_diff;
    t_side              r_g_side;
    logic [16:0]        r_g_lin;
    logic [31:0]        r_g_dist;
    logic [33:0]        h_prod;
    logic [44:0]        h_qprod;
    t_side              r_h_side;
    logic [16:0]        r_h_aura;
    logic               r_h_near;
    logic [15:0]        r_h_qd;
    logic [19:0]        i_a5;
    logic [20:0]        i_a25;
    logic [21:0]        i_a45;
    t_side              r_i_side;
    logic [16:0]        r_i_shine;
    logic [7:0]         r_i_ar, r_i_ag, r_i_ab;
    logic [24:0]        j_s220;
    logic [21:0]        j_s25;
    logic [24:0]        j_s137;
    logic [7:0]         j_r, j_g, j_b;
    logic [31:0]        n_o_rgba, r_o_rgba;
    logic               r_o_inside;

    // Handshake: all stages advance together unless the output is stalled.
    assign en          = !r_vld[NSTG-1] || o_pix.ready;
    assign i_pix.ready = en;
    assign i_cfg.ready = 1'b1;
    assign o_pix.valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_pix.valid};
        end
    end

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 13'd720;
            r_frame_height <= 13'd1280;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Dimensions saturate at the largest supported frame.
    assign frm_w = (r_frame_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_frame_width;
    assign frm_h = (r_frame_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_frame_height;
    assign shim_period = MOD_DIV_W'({1'b0, frm_w}) + MOD_DIV_W'({1'b0, frm_h})
                       + MOD_DIV_W'(200);

    // Stage A: frame test, offsets from the figure center, time products.
    always_comb begin
        n_a_inside = ({1'b0, i_pix.pixel_x} < frm_w) && ({1'b0, i_pix.pixel_y} < frm_h);
        n_a_dx     = $signed({2'b00, i_pix.pixel_x}) - $signed({2'b00, frm_w[DIM_W-1:1]});
        n_a_dy     = $signed({2'b00, i_pix.pixel_y}) - $signed({2'b00, frm_h[DIM_W-1:1]})
                   + 14'sd40;
        n_a_xy     = {1'b0, i_pix.pixel_x} + {1'b0, i_pix.pixel_y};
        n_a_t9     = {4'b0, i_pix.time_ms} * 28'd9;
        n_a_t7     = {3'b0, i_pix.time_ms} * 27'd7;
        a_t2003    = {11'b0, i_pix.time_ms} * 35'd2003;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_inside <= n_a_inside;
            r_a_dx     <= n_a_dx;
            r_a_dy     <= n_a_dy;
            r_a_xy     <= n_a_xy;
            r_a_t9     <= n_a_t9;
            r_a_t7     <= n_a_t7;
            r_a_p      <= a_t2003[21:16];
        end
    end

    // Stage B: squared distances, reciprocal products, aura pulse.
    always_comb begin
        b_dx      = {r_a_dx[13], r_a_dx};
        b_dy      = {r_a_dy[13], r_a_dy};
        b_hy      = b_dy + 15'sd25;
        b_ey      = b_dy + 15'sd65;
        b_lx      = b_dx + 15'sd30;
        b_rx      = b_dx - 15'sd30;
        b_pdx     = b_dx * b_dx;
        b_pdy     = b_dy * b_dy;
        b_phy     = b_hy * b_hy;
        b_pey     = b_ey * b_ey;
        b_plx     = b_lx * b_lx;
        b_prx     = b_rx * b_rx;
        b_prod5   = {28'b0, r_a_t9} * {28'b0, RCP_DIV5};
        b_prod10k = {27'b0, r_a_t7} * {27'b0, RCP_DIV10000};
        b_quad    = r_a_p[5:4];
        b_sidx    = b_quad[0] ? (5'd16 - {1'b0, r_a_p[3:0]}) : {1'b0, r_a_p[3:0]};
        b_amp     = {14'b0, sine_q(b_sidx)} * 30'd9830;
        n_b_pulse = b_quad[1] ? (17'd55706 - 17'(b_amp[29:15]))
                              : (17'd55706 + 17'(b_amp[29:15]));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_sx     <= b_pdx[25:0];
            r_b_sy     <= b_pdy[25:0];
            r_b_shy    <= b_phy[25:0];
            r_b_sey    <= b_pey[25:0];
            r_b_slx    <= b_plx[25:0];
            r_b_srx    <= b_prx[25:0];
            r_b_dx     <= r_a_dx;
            r_b_dy     <= r_a_dy;
            r_b_q5     <= b_prod5[55:30];
            r_b_q10k   <= b_prod10k[53:40];
            r_b_t9     <= r_a_t9;
            r_b_t7     <= r_a_t7;
            r_b_pulse  <= n_b_pulse;
            r_b_inside <= r_a_inside;
            r_b_xy     <= r_a_xy;
        end
    end

    // Stage C: figure and bar tests, radius squared, shimmer phase split.
    always_comb begin
        c_d2   = r_b_sx + r_b_sy;
        c_head = (27'(r_b_shy) + 27'(r_b_sx) <= 27'd5625) && (r_b_dy <= -14'sd25)
              && (27'(r_b_slx) + 27'(r_b_sey) > 27'd64)
              && (27'(r_b_srx) + 27'(r_b_sey) > 27'd64);
        c_a1   = 18'sd5 * 18'(r_b_dx) - 18'sd3 * 18'(r_b_dy) - 18'sd135;
        c_a2   = 18'sd5 * 18'(r_b_dx) + 18'sd3 * 18'(r_b_dy) + 18'sd135;
        c_ant  = (r_b_dy >= -14'sd135) && (r_b_dy <= -14'sd95)
              && (((c_a1 >= -18'sd20) && (c_a1 <= 18'sd20))
               || ((c_a2 >= -18'sd20) && (c_a2 <= 18'sd20)));
        c_torso = (r_b_dx >= -14'sd75) && (r_b_dx <= 14'sd75)
               && (r_b_dy >= -14'sd15) && (r_b_dy <= 14'sd75);
        c_arm  = (r_b_dy >= -14'sd10) && (r_b_dy <= 14'sd60)
              && (((r_b_dx >= -14'sd107) && (r_b_dx <= -14'sd83))
               || ((r_b_dx >= 14'sd83) && (r_b_dx <= 14'sd107)));
        c_leg  = (r_b_dy >= 14'sd80) && (r_b_dy <= 14'sd125)
              && (((r_b_dx >= -14'sd44) && (r_b_dx <= -14'sd16))
               || ((r_b_dx >= 14'sd16) && (r_b_dx <= 14'sd44)));
        c_bar  = (r_b_dy >= 14'sd220) && (r_b_dy <= 14'sd223)
              && (r_b_dx >= -14'sd130) && (r_b_dx <= 14'sd129);
        c_q5x5    = {2'b0, r_b_q5} * 28'd5;
        c_r5full  = r_b_t9 - c_q5x5;
        c_q10x    = {13'b0, r_b_q10k} * 27'd10000;
        c_r10full = r_b_t7 - c_q10x;

        n_c_side.in_frame = r_b_inside;
        n_c_side.robot    = c_head || c_ant || c_torso || c_arm || c_leg;
        n_c_side.bar      = c_bar;
        n_c_side.glow     = 8'd0;
        n_c_side.pulse    = r_b_pulse;
        n_c_side.xy       = r_b_xy;
        n_c_side.lo       = {r_b_q5[1:0], lo5_frac(c_r5full[2:0])};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_side <= n_c_side;
            r_c_rad  <= ISQ_RAD_W'({c_d2, 16'b0});
            r_c_hi   <= MOD_DIVD_W'(r_b_q5[25:2]);
            r_c_r10k <= c_r10full[13:0];
            r_c_dx   <= r_b_dx;
        end
    end

    // Radius in Q8 and the shimmer sweep phase.
    blpg_isqrt_pipe u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_c_rad),
        .o_root (isq_root)
    );

    blpg_mod_pipe u_mod (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_divd (r_c_hi),
        .i_div  (shim_period),
        .o_rem  (mod_rem)
    );

    // Stage D: column of the bar glow center.
    always_comb begin
        d_n13  = {3'b0, r_c_r10k} * 17'd13;
        d_prod = {24'b0, d_n13} * {17'b0, RCP_DIV500};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_side <= r_c_side;
            r_d_off  <= d_prod[40:32];
            r_d_dx   <= r_c_dx;
        end
    end

    // Stage E: glow falls off linearly over 30 columns.
    always_comb begin
        e_diff = $signed({r_d_dx[13], r_d_dx}) + 15'sd130 - $signed({6'b0, r_d_off});
        e_abs  = e_diff[14] ? 15'(-e_diff) : 15'(e_diff);
        e_g17  = 9'(5'd30 - e_abs[4:0]) * 9'd17;
        n_e_side      = r_d_side;
        n_e_side.glow = (e_abs < 15'd30) ? e_g17[8:1] : 8'd0;
    end

    // Side values wait for the square root and remainder pipelines.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_side <= n_e_side;
            r_dl[0]  <= r_e_side;
            for (int k = 1; k < ITER_STAGES - 2; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    // Stage F: radius scaled by 128/225, sweep position.
    assign f_prod = {25'b0, isq_root[16:0], 7'b0} * {24'b0, RCP_DIV225};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_side  <= r_dl[ITER_STAGES-3];
            r_f_far   <= isq_root >= ISQ_ROOT_W'(115200);
            r_f_q225  <= f_prod[47:32];
            r_f_sweep <= $signed({2'b00, mod_rem, r_dl[ITER_STAGES-3].lo}) - 32'sd6553600;
        end
    end

    // Stage G: linear aura falloff, distance to the sweep line.
    assign g_diff = $signed({3'b000, r_f_side.xy, 16'b0}) - r_f_sweep;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_side <= r_f_side;
            r_g_lin  <= r_f_far ? 17'd0 : (17'd65536 - {1'b0, r_f_q225});
            r_g_dist <= g_diff[31] ? 32'(-g_diff) : 32'(g_diff);
        end
    end

    // Stage H: pulsed aura strength, shimmer distance over 60.
    always_comb begin
        h_prod  = {17'b0, r_g_lin} * {17'b0, r_g_side.pulse};
        h_qprod = {25'b0, r_g_dist[21:2]} * {20'b0, RCP_DIV15};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_side <= r_g_side;
            r_h_aura <= h_prod[32:16];
            r_h_near <= r_g_dist < 32'd3932160;
            r_h_qd   <= h_qprod[43:28];
        end
    end

    // Stage I: shimmer intensity and background channels.
    always_comb begin
        i_a5  = {3'b0, r_h_aura} * 20'd5;
        i_a25 = {4'b0, r_h_aura} * 21'd25;
        i_a45 = {5'b0, r_h_aura} * 22'd45;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_side  <= r_h_side;
            r_i_shine <= r_h_near ? (17'd65536 - {1'b0, r_h_qd}) : 17'd0;
            r_i_ar    <= 8'd10 + {4'b0, i_a5[19:16]};
            r_i_ag    <= 8'd13 + {3'b0, i_a25[20:16]};
            r_i_ab    <= 8'd20 + {2'b0, i_a45[21:16]};
        end
    end

    // Stage J: figure shading, bar override, packing.
    always_comb begin
        j_s220 = {8'b0, r_i_shine} * 25'd220;
        j_s25  = {5'b0, r_i_shine} * 22'd25;
        j_s137 = {8'b0, r_i_shine} * 25'd137;
        if (r_i_side.bar) begin
            j_r = r_i_side.glow;
            j_g = (r_i_side.glow > 8'd60) ? r_i_side.glow : 8'd60;
            j_b = (r_i_side.glow > 8'd90) ? r_i_side.glow : 8'd90;
        end else if (r_i_side.robot) begin
            j_r = j_s220[23:16];
            j_g = 8'd230 + {2'b0, j_s25[21:16]};
            j_b = 8'd118 + j_s137[23:16];
        end else begin
            j_r = r_i_ar;
            j_g = r_i_ag;
            j_b = r_i_ab;
        end
        n_o_rgba = r_i_side.in_frame ? {8'hFF, j_b, j_g, j_r} : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_rgba   <= n_o_rgba;
            r_o_inside <= r_i_side.in_frame;
        end
    end

    assign o_pix.pixel_rgba = r_o_rgba;
    assign o_pix.inside_res = r_o_inside;

    // An accepted request always enters the first stage.
    a_in_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_vld[0])
        else $error("accepted pixel request did not enter the pipeline");

    // A stalled result blocks new requests.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.ready) |-> !i_pix.ready)
        else $error("input ready while the output is stalled");

    // Pixels outside the frame are black and transparent.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.inside_res) |-> (o_pix.pixel_rgba == 32'd0))
        else $error("outside pixel has a nonzero color");

    // Pixels inside the frame are opaque.
    a_inside_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.inside_res) |-> (o_pix.pixel_rgba[31:24] == 8'hFF))
        else $error("inside pixel is not opaque");

    // A width write lands in the width register.
    a_cfg_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.ready && (i_cfg.index == REG_FRAME_WIDTH))
        |=> (r_frame_width == $past(i_cfg.data)))
        else $error("frame width write was not stored");

endmodule
